// ===== design/cfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcp_pkg
// Shared types, constants and the tag decode used by the class file constant
// pool parser.
// ----------------------------------------------------------------------------
package cfcp_pkg;

  localparam logic [31:0] CP_MAGIC = 32'hCAFEBABE;

  localparam logic [7:0] TAG_UTF8         = 8'd1;
  localparam logic [7:0] TAG_INTEGER      = 8'd3;
  localparam logic [7:0] TAG_FLOAT        = 8'd4;
  localparam logic [7:0] TAG_LONG         = 8'd5;
  localparam logic [7:0] TAG_DOUBLE       = 8'd6;
  localparam logic [7:0] TAG_CLASS        = 8'd7;
  localparam logic [7:0] TAG_STRING       = 8'd8;
  localparam logic [7:0] TAG_FIELDREF     = 8'd9;
  localparam logic [7:0] TAG_METHODREF    = 8'd10;
  localparam logic [7:0] TAG_IFACEREF     = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE     = 8'd12;
  localparam logic [7:0] TAG_METHODHANDLE = 8'd15;
  localparam logic [7:0] TAG_METHODTYPE   = 8'd16;
  localparam logic [7:0] TAG_INVOKEDYN    = 8'd18;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_ENTRY     = 3'd1,
    KIND_UTF8_BYTE = 3'd2,
    KIND_BAD_MAGIC = 3'd3,
    KIND_BAD_TAG   = 3'd4
  } kind_e;

  typedef enum logic [9:0] {
    PH_MAGIC  = 10'b00_0000_0001,
    PH_MINOR  = 10'b00_0000_0010,
    PH_MAJOR  = 10'b00_0000_0100,
    PH_COUNT  = 10'b00_0000_1000,
    PH_TAG    = 10'b00_0001_0000,
    PH_FIELD  = 10'b00_0010_0000,
    PH_ULEN   = 10'b00_0100_0000,
    PH_UBYTES = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_HALT   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  entry_tag;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [15:0] entry_index;
    logic        last;
  } result_t;

  // bytes after the tag of a fixed-size entry, zero for an unknown tag
  function automatic logic [3:0] field_need(input logic [7:0] tag);
    logic [3:0] need;
    unique case (tag) inside
      TAG_CLASS, TAG_STRING, TAG_METHODTYPE: need = 4'd2;
      TAG_METHODHANDLE:                      need = 4'd3;
      TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF, TAG_NAMETYPE,
      TAG_INVOKEDYN, TAG_INTEGER, TAG_FLOAT: need = 4'd4;
      TAG_LONG, TAG_DOUBLE:                  need = 4'd8;
      default:                               need = 4'd0;
    endcase
    return need;
  endfunction

endpackage

// ===== design/cfcp_intf.sv =====
// ----------------------------------------------------------------------------
// cfcp byte and result channels
// Valid/ready channels carrying class file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface cfcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_file;

  modport source (output valid, output byte_value, output start_of_file, input ready);
  modport sink   (input valid, input byte_value, input start_of_file, output ready);
endinterface

interface cfcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  entry_tag;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [15:0] entry_index;
  logic        last;

  modport source (output valid, output kind, output entry_tag, output first_value,
                  output second_value, output entry_index, output last, input ready);
  modport sink   (input valid, input kind, input entry_tag, input first_value,
                  input second_value, input entry_index, input last, output ready);
endinterface

// ===== design/cfcp_core.sv =====
// ----------------------------------------------------------------------------
// cfcp_core
// Parser state registers and the per-byte decode that produces at most one
// result for each accepted byte.
// ----------------------------------------------------------------------------
module cfcp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_value_i,
  input  logic              start_of_file_i,
  output logic              res_valid_o,
  output cfcp_pkg::result_t res_o
);
  import cfcp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  byte_count_q, byte_count_d;
  logic [63:0] field_shift_q, field_shift_d;
  logic [15:0] slots_left_q, slots_left_d;
  logic [15:0] pool_index_q, pool_index_d;
  logic [7:0]  current_tag_q, current_tag_d;
  logic [15:0] string_left_q, string_left_d;
  logic [31:0] version_hold_q, version_hold_d;

  always_comb begin
    phase_e      ph;
    logic [2:0]  bc;
    logic [63:0] fs;
    logic [15:0] sl;
    logic [15:0] pi;
    logic [7:0]  tg;
    logic [15:0] strl;
    logic [31:0] vh;
    logic [63:0] sh;
    logic [15:0] w16;
    logic [3:0]  need;
    logic [15:0] take;
    logic        do_finish;
    logic        fin_final;

    // a start marker puts everything back to reset before the byte is used
    if (start_of_file_i) begin
      ph   = PH_MAGIC;
      bc   = '0;
      fs   = '0;
      sl   = '0;
      pi   = 16'd1;
      tg   = '0;
      strl = '0;
      vh   = '0;
    end else begin
      ph   = phase_q;
      bc   = byte_count_q;
      fs   = field_shift_q;
      sl   = slots_left_q;
      pi   = pool_index_q;
      tg   = current_tag_q;
      strl = string_left_q;
      vh   = version_hold_q;
    end

    phase_d        = ph;
    byte_count_d   = bc;
    field_shift_d  = fs;
    slots_left_d   = sl;
    pool_index_d   = pi;
    current_tag_d  = tg;
    string_left_d  = strl;
    version_hold_d = vh;

    sh        = {fs[55:0], byte_value_i};
    w16       = {fs[7:0], byte_value_i};
    need      = field_need(tg);
    take      = 16'd1;
    do_finish = 1'b0;

    res_valid_o        = 1'b0;
    res_o.kind         = KIND_HEADER;
    res_o.entry_tag    = '0;
    res_o.first_value  = '0;
    res_o.second_value = '0;
    res_o.entry_index  = '0;
    res_o.last         = 1'b0;

    unique case (ph)
      PH_MAGIC: begin
        field_shift_d = {32'd0, sh[31:0]};
        if (bc < 3'd3) begin
          byte_count_d = bc + 3'd1;
        end else begin
          byte_count_d = '0;
          if (sh[31:0] != CP_MAGIC) begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_BAD_MAGIC;
            res_o.first_value = sh[31:0];
            phase_d           = PH_HALT;
          end else begin
            field_shift_d = '0;
            phase_d       = PH_MINOR;
          end
        end
      end
      PH_MINOR, PH_MAJOR, PH_COUNT: begin
        field_shift_d = {48'd0, w16};
        if (bc < 3'd1) begin
          byte_count_d = bc + 3'd1;
        end else begin
          byte_count_d  = '0;
          field_shift_d = '0;
          if (ph == PH_MINOR) begin
            version_hold_d = {16'd0, w16};
            phase_d        = PH_MAJOR;
          end else if (ph == PH_MAJOR) begin
            version_hold_d = {w16, vh[15:0]};
            phase_d        = PH_COUNT;
          end else begin
            slots_left_d       = (w16 != 16'd0) ? w16 - 16'd1 : 16'd0;
            pool_index_d       = 16'd1;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_HEADER;
            res_o.first_value  = {16'd0, vh[31:16]};
            res_o.second_value = {16'd0, vh[15:0]};
            res_o.entry_index  = w16;
            res_o.last         = (w16 <= 16'd1);
            phase_d            = (w16 > 16'd1) ? PH_TAG : PH_DONE;
          end
        end
      end
      PH_TAG: begin
        current_tag_d = byte_value_i;
        byte_count_d  = '0;
        field_shift_d = '0;
        if (byte_value_i == TAG_UTF8) begin
          phase_d = PH_ULEN;
        end else if (field_need(byte_value_i) == 4'd0) begin
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_BAD_TAG;
          res_o.entry_tag   = byte_value_i;
          res_o.entry_index = pi;
          phase_d           = PH_HALT;
        end else begin
          phase_d = PH_FIELD;
        end
      end
      PH_FIELD: begin
        field_shift_d = sh;
        if (need == 4'd0 || ({1'b0, bc} + 4'd1) < need) begin
          byte_count_d = bc + 3'd1;
        end else begin
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ENTRY;
          res_o.entry_tag   = tg;
          res_o.entry_index = pi;
          if (need == 4'd2) begin
            res_o.first_value = {16'd0, sh[15:0]};
          end else if (need == 4'd3) begin
            res_o.first_value  = {24'd0, sh[23:16]};
            res_o.second_value = {16'd0, sh[15:0]};
          end else if (need == 4'd8) begin
            res_o.first_value  = sh[63:32];
            res_o.second_value = sh[31:0];
            take               = 16'd2;
          end else if (tg == TAG_INTEGER || tg == TAG_FLOAT) begin
            res_o.first_value = sh[31:0];
          end else begin
            res_o.first_value  = {16'd0, sh[31:16]};
            res_o.second_value = {16'd0, sh[15:0]};
          end
          res_o.last = (sl <= take);
          do_finish  = 1'b1;
        end
      end
      PH_ULEN: begin
        field_shift_d = {48'd0, w16};
        if (bc < 3'd1) begin
          byte_count_d = bc + 3'd1;
        end else begin
          byte_count_d      = '0;
          field_shift_d     = '0;
          string_left_d     = w16;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_ENTRY;
          res_o.entry_tag   = TAG_UTF8;
          res_o.first_value = {16'd0, w16};
          res_o.entry_index = pi;
          res_o.last        = (sl <= 16'd1);
          if (w16 == 16'd0) begin
            do_finish = 1'b1;
          end else begin
            phase_d = PH_UBYTES;
          end
        end
      end
      PH_UBYTES: begin
        string_left_d     = strl - 16'd1;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_UTF8_BYTE;
        res_o.entry_tag   = TAG_UTF8;
        res_o.first_value = {24'd0, byte_value_i};
        res_o.entry_index = pi;
        res_o.last        = (strl == 16'd1);
        do_finish         = (strl == 16'd1);
      end
      default: begin
      end
    endcase

    // close the entry: slot count saturates at zero on the final one
    fin_final = (sl <= take);
    if (do_finish) begin
      slots_left_d  = fin_final ? 16'd0 : sl - take;
      pool_index_d  = pi + take;
      phase_d       = fin_final ? PH_DONE : PH_TAG;
      byte_count_d  = '0;
      field_shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_MAGIC;
      byte_count_q   <= '0;
      field_shift_q  <= '0;
      slots_left_q   <= '0;
      pool_index_q   <= 16'd1;
      current_tag_q  <= '0;
      string_left_q  <= '0;
      version_hold_q <= '0;
    end else if (take_i) begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      field_shift_q  <= field_shift_d;
      slots_left_q   <= slots_left_d;
      pool_index_q   <= pool_index_d;
      current_tag_q  <= current_tag_d;
      string_left_q  <= string_left_d;
      version_hold_q <= version_hold_d;
    end
  end

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && start_of_file_i |=> phase_q == PH_MAGIC && byte_count_q == 3'd1)
    else $error("start marker did not restart magic check");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT || phase_q == PH_DONE) && !start_of_file_i |-> !res_valid_o)
    else $error("result produced while halted or finished");

  a_header_from_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_HEADER |-> phase_q == PH_COUNT)
    else $error("header result outside pool count phase");

  a_slots_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TAG || phase_q == PH_FIELD || phase_q == PH_ULEN ||
    phase_q == PH_UBYTES |-> slots_left_q != 16'd0)
    else $error("entry in progress with no slots left");

endmodule

// ===== design/cfcp_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfcp_out_reg
// Result register between the decode and the output channel; it frees up in
// the same cycle that the held result is taken.
// ----------------------------------------------------------------------------
module cfcp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              res_valid_i,
  input  cfcp_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              space_o,
  output logic              out_valid_o,
  output cfcp_pkg::result_t out_res_o
);
  import cfcp_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  a_take_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> !valid_q || out_ready_i)
    else $error("byte taken while result register blocked");

  a_new_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_valid_i |=> valid_q && res_q == $past(res_i))
    else $error("result not captured");

  a_no_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !res_valid_i |=> !valid_q)
    else $error("stale result left after silent byte");

endmodule

// ===== design/class_file_constant_pool_parser.sv =====
// ----------------------------------------------------------------------------
// class_file_constant_pool_parser
// Parses a class file header and constant pool one byte per request and
// emits a header result, one result per pool entry and one per utf8 byte,
// or an error result for a bad magic or an unknown tag.
//   channel  dir  request contents
//   byte_i   in   byte_value, start_of_file
//   res_o    out  kind, entry_tag, first_value, second_value, entry_index, last
//
// One byte is taken per cycle while the result register has space; its result,
// if any, shows on res_o the following cycle from the result register.
// A byte is taken whenever the result register is empty or being drained,
// so a stalled output holds back the input only while a result waits.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfcp_in_if.sink    byte_i,
  cfcp_out_if.source res_o
);
  import cfcp_pkg::*;

  logic    take;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign byte_i.ready = space;
  assign take         = byte_i.valid && space;

  cfcp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .byte_value_i    (byte_i.byte_value),
    .start_of_file_i (byte_i.start_of_file),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  cfcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (res_o.ready),
    .space_o     (space),
    .out_valid_o (res_o.valid),
    .out_res_o   (out_res)
  );

  assign res_o.kind         = out_res.kind;
  assign res_o.entry_tag    = out_res.entry_tag;
  assign res_o.first_value  = out_res.first_value;
  assign res_o.second_value = out_res.second_value;
  assign res_o.entry_index  = out_res.entry_index;
  assign res_o.last         = out_res.last;

endmodule
